### rtl/slrc_pkg.sv
// Shared types, codes and helpers for the sequenced link receive classifier.
`default_nettype none

package slrc_pkg;

	// Ack queue geometry
	localparam int unsigned ACK_QUEUE_DEPTH = 256;
	localparam int unsigned AQ_AW = (ACK_QUEUE_DEPTH > 1) ? $clog2(ACK_QUEUE_DEPTH) : 1;
	localparam int unsigned AQ_CW = $clog2(ACK_QUEUE_DEPTH + 1);

	// Field widths
	localparam int unsigned LEN_W  = 12;
	localparam int unsigned SEQN_W = 16;
	localparam int unsigned CNT_W  = 9;
	localparam int unsigned TICK_W = 16;

	// Register reset values and indexes
	localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 12'd596;
	localparam logic [TICK_W-1:0] RETRY_TICKS_RST = 16'd100;
	localparam logic              REG_MAX_PAYLOAD = 1'b0;
	localparam logic              REG_RETRY_TICKS = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SLOT   = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PT_DATA_FRAG  = 3'd0,
		PT_ACK        = 3'd1,
		PT_DATA_FINAL = 3'd2,
		PT_CONTROL    = 3'd3,
		PT_IC         = 3'd4,
		PT_CI         = 3'd5,
		PT_RSVD6      = 3'd6,
		PT_RSVD7      = 3'd7
	} pkt_type_t;

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_ACK_RX     = 4'd1,
		ACT_CTRL_OTHER = 4'd2,
		ACT_STATS_REQ  = 4'd3,
		ACT_LINK_RESET = 4'd4,
		ACT_CI_IGNORED = 4'd5,
		ACT_DATA_ACC   = 4'd6,
		ACT_DATA_REACK = 4'd7,
		ACT_DATA_DROP  = 4'd8,
		ACT_BAD_PKT    = 4'd9,
		ACT_LINK_UP    = 4'd10,
		ACT_UNCONN     = 4'd11
	} action_t;

	// Ack queue control from the classifier
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [SEQN_W-1:0] wdata;
	} aq_ctrl_t;

	// Ack queue status to the classifier
	typedef struct packed {
		logic [AQ_CW-1:0]  count;
		logic              empty;
		logic              full;
		logic [SEQN_W-1:0] front;
	} aq_stat_t;

	// seqn<<16 | type<<12 | len
	function automatic logic [31:0] make_header(input logic [LEN_W-1:0] len,
			input pkt_type_t ptype, input logic [SEQN_W-1:0] seqn);
		make_header = {seqn, 1'b0, ptype, len};
	endfunction

endpackage

`default_nettype wire

### rtl/slrc_ackq.sv
// Ack queue: circular buffer with registered read and a front-of-queue bypass.
`default_nettype none

module slrc_ackq
	import slrc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire aq_ctrl_t ctrl,
	output aq_stat_t      stat
);

	logic [SEQN_W-1:0] mem [ACK_QUEUE_DEPTH];
	logic [AQ_AW-1:0]  head_q, tail_q, head_d, tail_d;
	logic [AQ_CW-1:0]  count_q;
	logic [SEQN_W-1:0] rd_q, byp_data_q;
	logic              byp_q;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (ctrl.push) begin
			head_d = (head_q == AQ_AW'(ACK_QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		end
		if (ctrl.pop) begin
			tail_d = (tail_q == AQ_AW'(ACK_QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - 1'b1;
			end
			// write lands on the entry about to be read: serve it from the bypass
			byp_q <= ctrl.push && (head_q == tail_d);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ctrl.wdata;
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[head_q] <= ctrl.wdata;
		end
		rd_q <= mem[tail_d];
	end

	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q >= AQ_CW'(ACK_QUEUE_DEPTH));
	assign stat.front = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

### rtl/sequenced_link_receive_classifier.sv
// Top level: receive-side header classifier with ack queue and link state.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall  | kind pkt_length pkt_type pkt_seqn
//          |           |                    | control_byte read_queue_full
//  out     | output    | out_valid/out_stall| action seqn_out send_valid send_header
//          |           |                    | ack_count connected
//  cfg     | input     | cfg_we             | cfg_index cfg_data (write only)
//
// One event per cycle sustained while the output is not stalled. A transfer lands
// in the input register, is classified from there and its result is registered
// in the output register. The ack queue front is prefetched so a slot event pops
// in the same pass. Reset (arst_n low) clears link state, queue pointers and
// config to defaults; queue storage is not cleared. out_stall holds the output
// register and, once the input register is also full, raises in_stall.
`default_nettype none

module sequenced_link_receive_classifier
	import slrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// config write port
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_data,
	// event input
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [LEN_W-1:0]  pkt_length,
	input  wire logic [2:0]        pkt_type,
	input  wire logic [SEQN_W-1:0] pkt_seqn,
	input  wire logic [7:0]        control_byte,
	input  wire logic              read_queue_full,
	// result output
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [3:0]             action,
	output logic [SEQN_W-1:0]      seqn_out,
	output logic                   send_valid,
	output logic [31:0]            send_header,
	output logic [CNT_W-1:0]       ack_count,
	output logic                   connected
);

	// config registers
	logic [LEN_W-1:0]  max_payload_q;
	logic [TICK_W-1:0] retry_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			retry_ticks_q <= RETRY_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data[LEN_W-1:0];
				REG_RETRY_TICKS: retry_ticks_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic              valid_s1;
	kind_t             kind_s1;
	logic [LEN_W-1:0]  len_s1;
	pkt_type_t         type_s1;
	logic [SEQN_W-1:0] seqn_s1;
	logic [7:0]        cbyte_s1;
	logic              rqfull_s1;

	logic advance, in_xfer, process;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;
	assign process  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1   <= kind_t'(kind);
			len_s1    <= pkt_length;
			type_s1   <= pkt_type_t'(pkt_type);
			seqn_s1   <= pkt_seqn;
			cbyte_s1  <= control_byte;
			rqfull_s1 <= read_queue_full;
		end
	end

	// link state
	logic              link_up_q, link_up_d;
	logic [SEQN_W-1:0] exp_seqn_q, exp_seqn_d;
	logic [TICK_W-1:0] retry_age_q, retry_age_d;

	// ack queue
	aq_ctrl_t aq_ctrl;
	aq_stat_t aq_stat;

	slrc_ackq u_ackq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (aq_ctrl),
		.stat   (aq_stat)
	);

	// classification
	action_t           act_d;
	logic [SEQN_W-1:0] seqn_out_d;
	logic              send_d;
	logic [31:0]       hdr_d;
	logic [SEQN_W-1:0] seq_dist;
	logic [TICK_W:0]   age_next;
	logic              len_ok, data_ok;
	logic [AQ_CW-1:0]  cnt_next;

	assign seq_dist = seqn_s1 - exp_seqn_q;
	assign age_next = {1'b0, retry_age_q} + 1'b1;
	assign len_ok   = (len_s1 <= max_payload_q);
	assign data_ok  = (type_s1 == PT_DATA_FRAG || type_s1 == PT_DATA_FINAL)
	                  && (len_s1 != '0) && len_ok;

	always_comb begin
		act_d         = ACT_NONE;
		seqn_out_d    = '0;
		send_d        = 1'b0;
		hdr_d         = '0;
		link_up_d     = link_up_q;
		exp_seqn_d    = exp_seqn_q;
		retry_age_d   = retry_age_q;
		aq_ctrl.push  = 1'b0;
		aq_ctrl.pop   = 1'b0;
		aq_ctrl.wdata = seqn_s1;

		case (kind_s1)
			KIND_HEADER: begin
				if (!link_up_q) begin
					if (type_s1 == PT_CI) begin
						link_up_d   = 1'b1;
						exp_seqn_d  = '0;
						send_d      = 1'b1;
						hdr_d       = make_header('0, PT_CI, '0);
						retry_age_d = '0;
						act_d       = ACT_LINK_UP;
					end else begin
						if (type_s1 == PT_IC) begin
							send_d      = 1'b1;
							hdr_d       = make_header('0, PT_CI, '0);
							retry_age_d = '0;
						end
						act_d = ACT_UNCONN;
					end
				end else if (type_s1 == PT_ACK && len_s1 == '0) begin
					act_d      = ACT_ACK_RX;
					seqn_out_d = seqn_s1;
				end else if (type_s1 == PT_CONTROL && len_ok) begin
					act_d = (cbyte_s1 == 8'd0) ? ACT_STATS_REQ : ACT_CTRL_OTHER;
				end else if (type_s1 == PT_IC && len_s1 == '0) begin
					// peer reset: drop the link, answer with IC, keep queued acks
					link_up_d   = 1'b0;
					exp_seqn_d  = '0;
					send_d      = 1'b1;
					hdr_d       = make_header('0, PT_IC, '0);
					retry_age_d = '0;
					act_d       = ACT_LINK_RESET;
				end else if (type_s1 == PT_CI && len_s1 == '0) begin
					act_d = ACT_CI_IGNORED;
				end else if (data_ok) begin
					if (seq_dist[SEQN_W-1] && !aq_stat.full) begin
						// behind the window: re-ack
						aq_ctrl.push = 1'b1;
						act_d        = ACT_DATA_REACK;
						seqn_out_d   = seqn_s1;
					end else if (seqn_s1 == exp_seqn_q && !rqfull_s1 && !aq_stat.full) begin
						aq_ctrl.push = 1'b1;
						exp_seqn_d   = seqn_s1 + 1'b1;
						act_d        = ACT_DATA_ACC;
						seqn_out_d   = seqn_s1;
					end else begin
						act_d = ACT_DATA_DROP;
					end
				end else begin
					act_d = ACT_BAD_PKT;
				end
			end
			KIND_SLOT: begin
				if (link_up_q && !aq_stat.empty) begin
					aq_ctrl.pop = 1'b1;
					send_d      = 1'b1;
					hdr_d       = make_header('0, PT_ACK, aq_stat.front);
					seqn_out_d  = aq_stat.front;
				end
			end
			KIND_TICK: begin
				if (!link_up_q) begin
					if (age_next > {1'b0, retry_ticks_q}) begin
						send_d      = 1'b1;
						hdr_d       = make_header('0, PT_IC, '0);
						retry_age_d = '0;
					end else begin
						retry_age_d = age_next[TICK_W-1:0];
					end
				end
			end
			default: ;
		endcase

		// only a processed event may touch the queue
		if (!process) begin
			aq_ctrl.push = 1'b0;
			aq_ctrl.pop  = 1'b0;
		end
	end

	always_comb begin
		cnt_next = aq_stat.count;
		if (aq_ctrl.push) begin
			cnt_next = aq_stat.count + 1'b1;
		end else if (aq_ctrl.pop) begin
			cnt_next = aq_stat.count - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_up_q   <= 1'b0;
			exp_seqn_q  <= '0;
			retry_age_q <= RETRY_TICKS_RST;
		end else if (process) begin
			link_up_q   <= link_up_d;
			exp_seqn_q  <= exp_seqn_d;
			retry_age_q <= retry_age_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			action      <= act_d;
			seqn_out    <= seqn_out_d;
			send_valid  <= send_d;
			send_header <= hdr_d;
			ack_count   <= CNT_W'(cnt_next);
			connected   <= link_up_d;
		end
	end

	// checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		aq_stat.count <= AQ_CW'(ACK_QUEUE_DEPTH))
		else $error("ack queue count beyond depth");

	a_hdr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_valid |-> send_header == 32'd0)
		else $error("header driven without send");

	a_data_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_DATA_ACC || action == ACT_DATA_REACK) |-> connected)
		else $error("data acked while unconnected");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(aq_ctrl.push && aq_ctrl.pop))
		else $error("ack queue push and pop in one pass");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		aq_ctrl.pop |-> !aq_stat.empty && link_up_q)
		else $error("ack pop from empty queue or while down");

endmodule

`default_nettype wire
